>>> hw/rtl/nbfr_pkg.sv
// ----------------------------------------------------------------------------
// nbfr_pkg: shared definitions for the nested brace frame receiver
// Item codes, abort codes, register map and the result transfer layout.
// ----------------------------------------------------------------------------
package nbfr_pkg;

   // ring of message slots and the longest frame kept
   localparam int SLOTS   = 8;
   localparam int MAX_LEN = 1024;

   // field widths
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int SLOT_W  = 3;
   localparam int POS_W   = 10;
   localparam int LEN_W   = 11;
   localparam int ABORT_W = 2;
   localparam int FILL_W  = 4;
   localparam int DEPTH_W = 8;
   localparam int IDLE_W  = 8;

   // APB side
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   // abort codes
   localparam logic [ABORT_W-1:0] ABORT_NONE     = 2'd0;
   localparam logic [ABORT_W-1:0] ABORT_TIMEOUT  = 2'd1;
   localparam logic [ABORT_W-1:0] ABORT_OVERFLOW = 2'd2;

   // register indexes (word address paddr[3:2])
   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_OPEN    = 2'd1;
   localparam logic [1:0] REG_CLOSE   = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd5;
   localparam logic [BYTE_W-1:0] OPEN_RST    = 8'd123;
   localparam logic [BYTE_W-1:0] CLOSE_RST   = 8'd125;

   typedef struct packed {
      logic [BYTE_W-1:0]  byte_out;
      logic               write_strobe;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   position;
      logic               frame_end;
      logic [LEN_W-1:0]   frame_length;
      logic [ABORT_W-1:0] aborted;
      logic [FILL_W-1:0]  stored_frames;
   } rsp_type;

endpackage

>>> hw/rtl/nested_brace_frame_receiver.sv
// ----------------------------------------------------------------------------
// nested_brace_frame_receiver: nested marker frame cutter with slot ring
// Turns a stream of serial bytes, ticks and slot releases into slot writes.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one item per transfer, req_kind (byte / tick / release) and
//   req_data. An item is taken at a clock edge with req_valid high and
//   req_stall low.
//   rsp channel: zero or one result per item: a slot write command for each
//   frame byte, a report for each abandoned frame and for each release.
//   APB port: timeout_ticks at 0x0, open_marker at 0x4, close_marker at 0x8;
//   write only while the block is idle.
// Throughput
//   One item per cycle while req_stall is low. The item is decoded and
//   the frame state updated in the cycle it is taken; its result is registered.
// Stall behavior
//   Results sit in a two-entry output queue (result register plus skid).
//   req_stall rises only when both entries are full, so after rsp_stall
//   rises the input keeps flowing until one more result is held.
// Reset
//   Synchronous, active high: no frame open, slot 0, no filled slots, output
//   queue empty, registers back to timeout 5, markers '{' and '}'.
// ----------------------------------------------------------------------------
module nested_brace_frame_receiver
   import nbfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [BYTE_W-1:0]  req_data,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_byte_out,
   output logic               rsp_write_strobe,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [POS_W-1:0]   rsp_position,
   output logic               rsp_frame_end,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic [ABORT_W-1:0] rsp_aborted,
   output logic [FILL_W-1:0]  rsp_stored_frames,
   // configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0] timeout_ff, open_ff, close_ff;
   logic [1:0]        reg_idx;
   logic              cfg_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         open_ff    <= OPEN_RST;
         close_ff   <= CLOSE_RST;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_TIMEOUT: timeout_ff <= pwdata[BYTE_W-1:0];
            REG_OPEN:    open_ff    <= pwdata[BYTE_W-1:0];
            REG_CLOSE:   close_ff   <= pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TIMEOUT: prdata = DATA_W'(timeout_ff);
         REG_OPEN:    prdata = DATA_W'(open_ff);
         REG_CLOSE:   prdata = DATA_W'(close_ff);
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // frame state
   // ---------------------------------------------------------------------
   logic               in_frame_ff, in_frame_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [LEN_W-1:0]   bpos_ff, bpos_in;
   logic [SLOT_W-1:0]  wslot_ff, wslot_in;
   logic [FILL_W-1:0]  filled_ff, filled_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;

   // output queue: head is the result register, skid catches one more
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff;

   logic    item_fire, pop;
   logic    has_result;
   rsp_type result;

   // helpers for a byte inside a frame
   logic               is_open, is_close;
   logic [DEPTH_W-1:0] depth_up, depth_new;
   logic [LEN_W-1:0]   bpos_next;
   logic [IDLE_W-1:0]  idle_sat;
   logic               slot_free;
   logic [SLOT_W-1:0]  wslot_adv;

   assign req_stall = skid_valid_ff;
   assign item_fire = req_valid && !req_stall;
   assign pop       = rsp_valid_ff && !rsp_stall;

   assign is_open   = (req_data == open_ff);
   assign is_close  = (req_data == close_ff);
   // depth saturates at the top; it is at least one inside a frame
   assign depth_up  = (is_open && depth_ff != '1) ? depth_ff + 1'b1 : depth_ff;
   assign depth_new = is_close ? depth_up - 1'b1 : depth_up;
   assign bpos_next = bpos_ff + 1'b1;
   assign idle_sat  = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign slot_free = (filled_ff < FILL_W'(SLOTS));
   assign wslot_adv = (wslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : wslot_ff + 1'b1;

   always_comb begin
      in_frame_in = in_frame_ff;
      depth_in    = depth_ff;
      bpos_in     = bpos_ff;
      wslot_in    = wslot_ff;
      filled_in   = filled_ff;
      idle_in     = idle_ff;

      has_result           = 1'b0;
      result               = '0;
      result.slot          = wslot_ff;
      result.stored_frames = filled_ff;
      result.aborted       = ABORT_NONE;

      case (req_kind)
         KIND_BYTE: begin
            idle_in = '0;
            if (!in_frame_ff) begin
               // bytes outside a frame are dropped unless they open one
               if (is_open) begin
                  in_frame_in         = 1'b1;
                  depth_in            = DEPTH_W'(1);
                  bpos_in             = LEN_W'(1);
                  has_result          = 1'b1;
                  result.byte_out     = req_data;
                  result.write_strobe = 1'b1;
               end
            end else if (bpos_ff >= LEN_W'(MAX_LEN)) begin
               // frame would overrun the slot: drop it, keep the slot
               in_frame_in    = 1'b0;
               depth_in       = '0;
               bpos_in        = '0;
               has_result     = 1'b1;
               result.aborted = ABORT_OVERFLOW;
            end else begin
               has_result          = 1'b1;
               result.byte_out     = req_data;
               result.write_strobe = 1'b1;
               result.position     = bpos_ff[POS_W-1:0];
               bpos_in             = bpos_next;
               depth_in            = depth_new;
               if (is_close && depth_new == '0) begin
                  // outermost close: commit the slot if the ring has room
                  if (slot_free) begin
                     wslot_in  = wslot_adv;
                     filled_in = filled_ff + 1'b1;
                  end
                  in_frame_in          = 1'b0;
                  bpos_in              = '0;
                  result.frame_end     = 1'b1;
                  result.frame_length  = bpos_next;
                  result.stored_frames = filled_in;
               end
            end
         end
         KIND_TICK: begin
            if (in_frame_ff) begin
               idle_in = idle_sat;
               if (idle_sat > timeout_ff) begin
                  in_frame_in    = 1'b0;
                  depth_in       = '0;
                  bpos_in        = '0;
                  idle_in        = '0;
                  has_result     = 1'b1;
                  result.aborted = ABORT_TIMEOUT;
               end
            end
         end
         KIND_RELEASE: begin
            if (filled_ff != '0) begin
               filled_in = filled_ff - 1'b1;
            end
            has_result           = 1'b1;
            result.stored_frames = filled_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         depth_ff    <= '0;
         bpos_ff     <= '0;
         wslot_ff    <= '0;
         filled_ff   <= '0;
         idle_ff     <= '0;
      end else if (item_fire) begin
         in_frame_ff <= in_frame_in;
         depth_ff    <= depth_in;
         bpos_ff     <= bpos_in;
         wslot_ff    <= wslot_in;
         filled_ff   <= filled_in;
         idle_ff     <= idle_in;
      end
   end

   // ---------------------------------------------------------------------
   // output queue; skid only fills while the head is stalled
   // ---------------------------------------------------------------------
   logic push;
   assign push = item_fire && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (!rsp_valid_ff) begin
         rsp_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= skid_valid_ff ? skid_ff : result;
      end else if (!rsp_valid_ff) begin
         rsp_ff <= result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_out      = rsp_ff.byte_out;
   assign rsp_write_strobe  = rsp_ff.write_strobe;
   assign rsp_slot          = rsp_ff.slot;
   assign rsp_position      = rsp_ff.position;
   assign rsp_frame_end     = rsp_ff.frame_end;
   assign rsp_frame_length  = rsp_ff.frame_length;
   assign rsp_aborted       = rsp_ff.aborted;
   assign rsp_stored_frames = rsp_ff.stored_frames;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty result register");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (depth_ff == '0 && bpos_ff == '0))
      else $error("frame state left over outside a frame");

   a_frame_live: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (depth_ff != '0 && bpos_ff != '0))
      else $error("open frame with zero depth or length");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(SLOTS))
      else $error("filled slot count beyond ring size");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      bpos_ff <= LEN_W'(MAX_LEN))
      else $error("frame length beyond limit");

endmodule

>>> tb/nested_brace_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nested_brace_frame_receiver_tb: self-checking bench for the frame receiver
// Drives byte, tick, release and unused items and checks each result
// transfer against an in-bench tracker of frame, slot and idle state. It
// also walks the register settings (extremes and equal markers included)
// and applies random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module nested_brace_frame_receiver_tb;
   import nbfr_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int CHUNKS      = 15;
   localparam int CHUNK_ITEMS = 12;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } rx_item_type;

   // DUT ports; the inputs are known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [KIND_W-1:0]  req_kind = '0;
   logic [BYTE_W-1:0]  req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [BYTE_W-1:0]  rsp_byte_out;
   logic               rsp_write_strobe;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [POS_W-1:0]   rsp_position;
   logic               rsp_frame_end;
   logic [LEN_W-1:0]   rsp_frame_length;
   logic [ABORT_W-1:0] rsp_aborted;
   logic [FILL_W-1:0]  rsp_stored_frames;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   // stimulus backlog and the reports the tracker says are due
   rx_item_type rx_backlog[$];
   rsp_type     frame_reports[$];

   // tracker copy of the registers
   logic [BYTE_W-1:0] cfg_timeout = TIMEOUT_RST;
   logic [BYTE_W-1:0] cfg_open    = OPEN_RST;
   logic [BYTE_W-1:0] cfg_close   = CLOSE_RST;

   // tracker copy of the frame state
   bit                framing    = 1'b0;
   logic [7:0]        depth      = '0;
   logic [LEN_W-1:0]  fill_pos   = '0;
   logic [SLOT_W-1:0] cur_slot   = '0;
   logic [FILL_W-1:0] filled     = '0;
   logic [7:0]        idle_count = '0;

   // idle percentages, changed by the stimulus as the run goes on
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // bookkeeping
   int errors = 0;
   int items_sent = 0;
   int items_ignored = 0;
   int reports_checked = 0;
   int frames_closed = 0;
   int timeouts = 0;
   int overflows = 0;
   int releases = 0;
   int settings_used = 1;
   int cycle_count = 0;

   nested_brace_frame_receiver uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_write_strobe  (rsp_write_strobe),
      .rsp_slot          (rsp_slot),
      .rsp_position      (rsp_position),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_aborted       (rsp_aborted),
      .rsp_stored_frames (rsp_stored_frames),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Frame tracker
   // -------------------------------------------------------------------------

   // closing or abandoning a frame clears everything but the slot ring
   function automatic void drop_frame();
      framing    = 1'b0;
      depth      = '0;
      fill_pos   = '0;
      idle_count = '0;
   endfunction

   // Updates the tracked state for one accepted item and queues its report.
   function automatic void track_frame(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data);
      rsp_type           r;
      bit                give;
      logic [SLOT_W-1:0] start_slot;
      r    = '0;
      give = 1'b0;
      case (kind)
         KIND_BYTE: begin
            idle_count = '0;
            if (!framing) begin
               // outside a frame only the open marker counts
               if (data == cfg_open) begin
                  framing        = 1'b1;
                  depth          = 8'd1;
                  fill_pos       = LEN_W'(1);
                  r.byte_out     = data;
                  r.write_strobe = 1'b1;
                  give           = 1'b1;
               end
            end else if (fill_pos >= MAX_LEN) begin
               // slot full: byte dropped, frame abandoned, slot kept
               drop_frame();
               r.aborted = ABORT_OVERFLOW;
               give      = 1'b1;
               overflows++;
            end else begin
               r.byte_out     = data;
               r.write_strobe = 1'b1;
               r.position     = fill_pos[POS_W-1:0];
               give           = 1'b1;
               fill_pos++;
               // open then close on the same byte when the markers are equal
               if (data == cfg_open && depth != 8'hFF) depth++;
               if (data == cfg_close) begin
                  depth--;
                  if (depth == 0) begin
                     r.frame_end    = 1'b1;
                     r.frame_length = fill_pos;
                     start_slot     = cur_slot;
                     // ring full: next frame reuses this slot
                     if (filled < SLOTS) begin
                        cur_slot++;
                        filled++;
                     end
                     drop_frame();
                     r.slot = start_slot;
                     frames_closed++;
                  end
               end
            end
         end
         KIND_TICK: begin
            if (framing) begin
               if (idle_count != 8'hFF) idle_count++;
               if (idle_count > cfg_timeout) begin
                  drop_frame();
                  r.aborted = ABORT_TIMEOUT;
                  give      = 1'b1;
                  timeouts++;
               end
            end
         end
         KIND_RELEASE: begin
            // a release on an empty ring still reports
            if (filled != 0) filled--;
            give = 1'b1;
            releases++;
         end
         default: ;
      endcase
      if (!r.frame_end) r.slot = cur_slot;
      r.stored_frames = filled;
      if (give) frame_reports.push_back(r);
      else items_ignored++;
   endfunction

   // -------------------------------------------------------------------------
   // Driver: one item per transfer, payload held while stalled
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_items
      bit          fire;
      rx_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            track_frame(req_kind, req_data);
            items_sent++;
         end
         if (!req_valid || fire) begin
            if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = rx_backlog.pop_front();
               req_valid <= 1'b1;
               req_kind  <= item.kind;
               req_data  <= item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: compares each result transfer with the oldest due report
   // -------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_reports.size() == 0) begin
               $error("result transfer with no report due");
               errors++;
            end else begin
               want = frame_reports.pop_front();
               check_field("byte_out", 16'(want.byte_out), 16'(rsp_byte_out));
               check_field("write_strobe", 16'(want.write_strobe),
                           16'(rsp_write_strobe));
               check_field("slot", 16'(want.slot), 16'(rsp_slot));
               check_field("position", 16'(want.position), 16'(rsp_position));
               check_field("frame_end", 16'(want.frame_end), 16'(rsp_frame_end));
               check_field("frame_length", 16'(want.frame_length),
                           16'(rsp_frame_length));
               check_field("aborted", 16'(want.aborted), 16'(rsp_aborted));
               check_field("stored_frames", 16'(want.stored_frames),
                           16'(rsp_stored_frames));
               reports_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at cycle limit %0d with %0d reports due",
                  CYCLE_LIMIT, frame_reports.size());
         $display("Verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus builders (no time passes here)
   // -------------------------------------------------------------------------
   function automatic void push_item(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] data);
      rx_item_type item;
      item.kind = kind;
      item.data = data;
      rx_backlog.push_back(item);
   endfunction

   // a frame byte that is neither marker
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom); while (b == cfg_open || b == cfg_close);
      return b;
   endfunction

   // mostly a short pause, now and then just past the limit
   function automatic int tick_run_len();
      if ($urandom_range(99) < 8) return cfg_timeout + 1;
      if (cfg_timeout == 0) return 0;
      return $urandom_range(1, (cfg_timeout > 4) ? 4 : cfg_timeout);
   endfunction

   // well-formed nested frame with random body; a few are left unclosed
   function automatic int gen_frame();
      int n;
      int open_depth;
      int pick;
      int ticks;
      push_item(KIND_BYTE, cfg_open);
      n          = 1;
      open_depth = 1;
      repeat ($urandom_range(0, 14)) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            push_item(KIND_BYTE, cfg_open);
            open_depth++;
         end else if (pick < 30 && open_depth > 1) begin
            push_item(KIND_BYTE, cfg_close);
            open_depth--;
         end else if (pick < 40) begin
            ticks = tick_run_len();
            repeat (ticks) push_item(KIND_TICK, BYTE_W'($urandom));
            n += ticks - 1;
         end else begin
            push_item(KIND_BYTE, plain_byte());
         end
         n++;
      end
      if ($urandom_range(99) < 10) return n;
      repeat (open_depth) push_item(KIND_BYTE, cfg_close);
      return n + open_depth;
   endfunction

   // frames, releases, stray bytes, stray ticks and unused items
   function automatic void gen_chunk(input int budget);
      int made;
      int pick;
      made = 0;
      while (made < budget) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            made += gen_frame();
         end else if (pick < 80) begin
            push_item(KIND_RELEASE, BYTE_W'($urandom));
            made++;
         end else if (pick < 88) begin
            push_item(KIND_BYTE, BYTE_W'($urandom));
         end else if (pick < 95) begin
            repeat (tick_run_len()) push_item(KIND_TICK, BYTE_W'($urandom));
         end else begin
            push_item(KIND_UNUSED, BYTE_W'($urandom));
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Timed helpers
   // -------------------------------------------------------------------------

   // wait until everything sent has reported, then let no-result items settle
   task automatic drain();
      do @(negedge clock);
      while (rx_backlog.size() != 0 || req_valid || frame_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // APB write then read back
   task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
      logic [DATA_W-1:0] seen;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      seen = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (seen !== DATA_W'(val)) begin
         $error("register %0d read back %0h, wrote %0h", idx, seen, val);
         errors++;
      end
      case (idx)
         REG_TIMEOUT: cfg_timeout = val;
         REG_OPEN:    cfg_open    = val;
         REG_CLOSE:   cfg_close   = val;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int which);
      logic [BYTE_W-1:0] t;
      logic [BYTE_W-1:0] o;
      logic [BYTE_W-1:0] c;
      case (which)
         0: begin t = 8'd0;   o = 8'h00; c = 8'hFF; end
         1: begin t = 8'd254; o = 8'hFF; c = 8'h00; end
         // equal markers: frames end only by timeout or overflow
         2: begin t = 8'd2;   o = 8'h5A; c = 8'h5A; end
         3: begin
            t = BYTE_W'($urandom_range(0, 254));
            o = BYTE_W'($urandom);
            c = BYTE_W'($urandom);
         end
         default: begin t = TIMEOUT_RST; o = OPEN_RST; c = CLOSE_RST; end
      endcase
      write_reg(REG_TIMEOUT, t);
      write_reg(REG_OPEN, o);
      write_reg(REG_CLOSE, c);
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int chunk;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender idles more lightly than the receiver stalls
      send_idle_pct  = 33;
      recv_stall_pct = 46;

      // directed: empty release, unused kind, stray bytes and tick
      push_item(KIND_RELEASE, 8'h00);
      push_item(KIND_UNUSED, 8'hFF);
      push_item(KIND_BYTE, 8'h00);
      push_item(KIND_BYTE, 8'hFF);
      push_item(KIND_BYTE, CLOSE_RST);
      push_item(KIND_TICK, 8'h00);
      // nested frame with extreme data bytes
      push_item(KIND_BYTE, OPEN_RST);
      push_item(KIND_BYTE, 8'hFF);
      push_item(KIND_BYTE, OPEN_RST);
      push_item(KIND_BYTE, 8'h00);
      push_item(KIND_BYTE, CLOSE_RST);
      push_item(KIND_BYTE, CLOSE_RST);
      // idle ticks up to the limit, a byte clears them, then one too many
      push_item(KIND_BYTE, OPEN_RST);
      repeat (5) push_item(KIND_TICK, 8'h00);
      push_item(KIND_BYTE, 8'h41);
      repeat (6) push_item(KIND_TICK, 8'hFF);
      drain();

      // depth saturation: 256 opens, 255 closes end the frame
      repeat (256) push_item(KIND_BYTE, cfg_open);
      repeat (255) push_item(KIND_BYTE, cfg_close);
      // fills the slot to the last position, then one byte too many
      push_item(KIND_BYTE, cfg_open);
      repeat (MAX_LEN - 1) push_item(KIND_BYTE, plain_byte());
      push_item(KIND_BYTE, cfg_close);
      repeat (3) push_item(KIND_RELEASE, 8'h00);
      drain();

      // random chunks; new register setting every third chunk
      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk % 3 == 0) begin
            drain();
            apply_setting(chunk / 3);
         end
         if (chunk == CHUNKS / 3) begin
            send_idle_pct  = 46;
            recv_stall_pct = 33;
         end
         if (chunk == 2 * CHUNKS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         gen_chunk(CHUNK_ITEMS);
         do @(negedge clock); while (rx_backlog.size() != 0);
      end

      drain();
      repeat (16) @(negedge clock);

      $display("Covered %0d items (%0d without a report) under %0d register settings;",
               items_sent, items_ignored, settings_used);
      $display("%0d reports checked: %0d frames, %0d timeouts, %0d overflows, %0d releases.",
               reports_checked, frames_closed, timeouts, overflows, releases);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
